### rtl/cpba_pkg.sv
// ----------------------------------------------------------------------------
// cpba_pkg
// Shared sizes, request codes and controller states of the contiguous
// page bitmap allocator.
// ----------------------------------------------------------------------------
package cpba_pkg;

   // Number of pages that the bitmap can hold.
   localparam int MAX_PAGES = 256;
   // Bits of a page index, and of a count that can hold MAX_PAGES itself.
   localparam int PAGE_W    = $clog2(MAX_PAGES);
   localparam int CNT_W     = $clog2(MAX_PAGES + 1);

   // Field widths of the request and response items.
   localparam int ACTION_W  = 2;
   localparam int START_W   = 8;
   localparam int LEN_W     = 9;
   localparam int STATUS_W  = 1;
   localparam int GRANT_W   = 8;
   localparam int FREE_W    = 9;

   localparam int REQ_BITS  = START_W + LEN_W;
   localparam int RSP_BITS  = STATUS_W + GRANT_W + FREE_W;
   localparam int REQ_DATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   // Request codes carried on req_tuser.
   localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_FREE  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd2;

   // Response status codes.
   localparam logic [STATUS_W-1:0] ST_OK      = 1'b0;
   localparam logic [STATUS_W-1:0] ST_REFUSED = 1'b1;

   // Sequencer states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_COUNT,
      S_WINDOW,
      S_SCAN,
      S_SKIP,
      S_MARK,
      S_POINTER,
      S_FREE
   } state_type;

endpackage

### rtl/contiguous_page_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// contiguous_page_bitmap_allocator
// Next-fit allocator of contiguous page runs over a bitmap of used pages.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel takes one request per transfer: req_tuser holds the
//   action (allocate, free, query), req_tdata the start page and run length.
//   The rsp channel returns exactly one response per request: status, the
//   granted start page and the free page count after the request.
//   The csr channel writes the number of managed pages.
// Operation:
//   A query, a free with nothing to free, an unknown action or an allocation
//   refused up front answers in the cycle after its transfer. Any other
//   request runs on a single page cursor that visits one bitmap bit per
//   cycle: an allocation checks each window, scans it, skips used pages,
//   marks the found run and passes on to the next free page for the next-fit
//   pointer; a free clears the pages of the clamped run. req_tready is low
//   while the cursor works. A csr transfer starts a recount of the free
//   pages, also with req_tready low.
// Reset and stalls:
//   Reset marks every page free, sets 256 managed pages and the next-fit
//   pointer to page 0. The response waits in an output register; a new
//   request is taken in the cycle the pending response transfers.
// ----------------------------------------------------------------------------
module contiguous_page_bitmap_allocator
   import cpba_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Request channel.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // req_tdata from bit 0 up: start_page[7:0], run_length[8:0], zero fill.
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // req_tuser: action[1:0].
   input  logic [ACTION_W-1:0]   req_tuser,
   // Response channel.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // rsp_tdata from bit 0 up: status, granted_start[7:0], free_pages[8:0],
   // zero fill.
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // Configuration channel: number of managed pages.
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [LEN_W-1:0]      csr_wdata
);

   // Registers.
   state_type              state_ff,    state_in;
   logic [MAX_PAGES-1:0]   used_map_ff, used_map_in;
   logic [LEN_W-1:0]       pages_ff,    pages_in;
   logic [CNT_W-1:0]       ptr_ff,      ptr_in;
   logic [CNT_W-1:0]       free_ff,     free_in;
   logic [CNT_W-1:0]       idx_ff,      idx_in;
   logic [CNT_W-1:0]       base_ff,     base_in;
   logic [CNT_W-1:0]       last_ff,     last_in;
   logic [CNT_W-1:0]       end_ff,      end_in;
   logic [CNT_W-1:0]       len_ff,      len_in;
   logic                   wrap_ff,     wrap_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [GRANT_W-1:0]     rsp_start_ff,  rsp_start_in;
   logic [FREE_W-1:0]      rsp_free_ff,   rsp_free_in;

   // Decoded request and handshakes.
   logic [ACTION_W-1:0]    req_action;
   logic [CNT_W-1:0]       req_start;
   logic [CNT_W-1:0]       req_len;
   logic                   req_fire;
   logic                   rsp_fire;
   logic                   csr_fire;

   // Shared cursor unit.
   logic [CNT_W-1:0]       n_pages;
   logic [CNT_W-1:0]       idx_plus;
   logic [PAGE_W-1:0]      idx_page;
   logic                   idx_used;
   logic                   idx_end;
   logic                   window_fits;
   logic                   alloc_refuse;
   logic                   free_some;
   logic [CNT_W:0]         free_end_sum;

   assign req_action = req_tuser;
   assign req_start  = CNT_W'(req_tdata[START_W-1:0]);
   assign req_len    = CNT_W'(req_tdata[START_W +: LEN_W]);

   // The response register is free, or frees up in this cycle.
   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready) && !csr_valid;
   assign csr_ready  = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_valid_ff && rsp_tready;
   assign csr_fire   = csr_valid && csr_ready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_free_ff, rsp_start_ff, rsp_status_ff});

   // Page count clamped to the range the bitmap supports.
   always_comb begin
      if (pages_ff == '0) begin
         n_pages = CNT_W'(1);
      end else if ((CNT_W+1)'(pages_ff) > (CNT_W+1)'(MAX_PAGES)) begin
         n_pages = CNT_W'(MAX_PAGES);
      end else begin
         n_pages = CNT_W'(pages_ff);
      end
   end

   // Cursor: one bitmap bit, one increment and one bound compare per cycle.
   assign idx_plus    = idx_ff + CNT_W'(1);
   assign idx_page    = idx_ff[PAGE_W-1:0];
   assign idx_used    = used_map_ff[idx_page];
   assign idx_end     = (idx_ff >= n_pages);
   assign window_fits = (base_ff <= n_pages) && (len_ff <= (n_pages - base_ff));

   // Up-front checks on a new request.
   assign alloc_refuse = (req_len == '0) || (req_len > n_pages) || (req_len > free_ff);
   assign free_some    = (req_start < n_pages) && (req_len != '0);
   assign free_end_sum = (CNT_W+1)'(req_start) + (CNT_W+1)'(req_len);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (csr_fire) begin
               state_in = S_COUNT;
            end else if (req_fire) begin
               if ((req_action == ACT_ALLOC) && !alloc_refuse) begin
                  state_in = S_WINDOW;
               end else if ((req_action == ACT_FREE) && free_some) begin
                  state_in = S_FREE;
               end
            end
         end
         S_COUNT: begin
            if (idx_ff == CNT_W'(MAX_PAGES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_WINDOW: begin
            if (window_fits) begin
               state_in = S_SCAN;
            end else if (!wrap_ff) begin
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            if (idx_used) begin
               state_in = S_SKIP;
            end else if (idx_ff == last_ff) begin
               state_in = S_MARK;
            end
         end
         S_SKIP: begin
            if (idx_end || !idx_used) begin
               state_in = S_WINDOW;
            end
         end
         S_MARK: begin
            if (idx_ff == last_ff) begin
               state_in = S_POINTER;
            end
         end
         S_POINTER: begin
            if (idx_end || !idx_used) begin
               state_in = S_IDLE;
            end
         end
         S_FREE: begin
            if (idx_plus == end_ff) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Datapath and response register.
   always_comb begin
      used_map_in   = used_map_ff;
      pages_in      = pages_ff;
      ptr_in        = ptr_ff;
      free_in       = free_ff;
      idx_in        = idx_ff;
      base_in       = base_ff;
      last_in       = last_ff;
      end_in        = end_ff;
      len_in        = len_ff;
      wrap_in       = wrap_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_fire;
      rsp_status_in = rsp_status_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_free_in   = rsp_free_ff;

      case (state_ff)
         S_IDLE: begin
            if (csr_fire) begin
               // New page count: recount the free pages from scratch.
               pages_in = csr_wdata;
               free_in  = '0;
               idx_in   = '0;
            end else if (req_fire) begin
               len_in  = req_len;
               base_in = ptr_ff;
               wrap_in = (ptr_ff != '0);
               idx_in  = req_start;
               if (free_end_sum > (CNT_W+1)'(n_pages)) begin
                  end_in = n_pages;
               end else begin
                  end_in = free_end_sum[CNT_W-1:0];
               end
               // Requests that answer at once.
               if (!(((req_action == ACT_ALLOC) && !alloc_refuse) ||
                     ((req_action == ACT_FREE) && free_some))) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = (req_action == ACT_ALLOC) ? ST_REFUSED : ST_OK;
                  rsp_start_in  = '0;
                  rsp_free_in   = FREE_W'(free_ff);
               end
            end
         end
         S_COUNT: begin
            if (!idx_end && !idx_used) begin
               free_in = free_ff + CNT_W'(1);
            end
            idx_in = idx_plus;
         end
         S_WINDOW: begin
            if (window_fits) begin
               idx_in  = base_ff;
               last_in = base_ff + len_ff - CNT_W'(1);
            end else if (wrap_ff) begin
               wrap_in = 1'b0;
               base_in = '0;
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_REFUSED;
               rsp_start_in  = '0;
               rsp_free_in   = FREE_W'(free_ff);
            end
         end
         S_SCAN: begin
            if (idx_used) begin
               idx_in = idx_plus;
            end else if (idx_ff == last_ff) begin
               // Window is clear: go back and mark it.
               idx_in  = base_ff;
               free_in = free_ff - len_ff;
            end else begin
               idx_in = idx_plus;
            end
         end
         S_SKIP: begin
            if (idx_end) begin
               base_in = n_pages;
            end else if (!idx_used) begin
               base_in = idx_ff;
            end else begin
               idx_in = idx_plus;
            end
         end
         S_MARK: begin
            used_map_in[idx_page] = 1'b1;
            idx_in                = idx_plus;
         end
         S_POINTER: begin
            if (idx_end || !idx_used) begin
               ptr_in        = idx_end ? n_pages : idx_ff;
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_start_in  = GRANT_W'(base_ff);
               rsp_free_in   = FREE_W'(free_ff);
            end else begin
               idx_in = idx_plus;
            end
         end
         S_FREE: begin
            if (idx_used) begin
               used_map_in[idx_page] = 1'b0;
               free_in               = free_ff + CNT_W'(1);
            end
            idx_in = idx_plus;
            if (idx_plus == end_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_start_in  = '0;
               rsp_free_in   = FREE_W'(free_in);
            end
         end
         default: begin
         end
      endcase
   end

   // Control state and bitmap.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_map_ff  <= '0;
         pages_ff     <= LEN_W'(MAX_PAGES);
         ptr_ff       <= '0;
         free_ff      <= CNT_W'(MAX_PAGES);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_map_ff  <= used_map_in;
         pages_ff     <= pages_in;
         ptr_ff       <= ptr_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Cursor working registers and response payload.
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      base_ff       <= base_in;
      last_ff       <= last_in;
      end_ff        <= end_in;
      len_ff        <= len_in;
      wrap_ff       <= wrap_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_free_ff   <= rsp_free_in;
   end

   // The free count never exceeds the bitmap size.
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      free_ff <= CNT_W'(MAX_PAGES))
      else $error("free page count above bitmap size");

   // An accepted request is either still at work or has its response waiting.
   a_req_progress: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> ((state_ff != S_IDLE) || rsp_valid_ff))
      else $error("request accepted without work or response");

   // A refused allocation reports start page zero.
   a_refused_start: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == ST_REFUSED)) |-> (rsp_start_ff == '0))
      else $error("refused allocation with nonzero start");

   // The scan and mark cursors stay inside the managed pages.
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_SCAN) || (state_ff == S_MARK)) |-> (idx_ff < n_pages))
      else $error("cursor beyond last page");

   // A configuration write starts a recount.
   a_csr_recount: assert property (@(posedge clock) disable iff (reset)
      csr_fire |=> (state_ff == S_COUNT))
      else $error("configuration write without recount");

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Contiguous page bitmap allocator testbench
// Drives allocate, free and query requests and writes of the managed page
// count. A scoreboard keeps its own copy of the page map and next-fit pointer,
// works out the response to every accepted request and checks each response
// field by field, in order. Both stream sides insert random idle bursts.
// ----------------------------------------------------------------------------
import cpba_pkg::*;

typedef struct packed {
   logic [STATUS_W-1:0] status;
   logic [GRANT_W-1:0]  granted;
   logic [FREE_W-1:0]   free_count;
} reply_type;

// Page map scoreboard: predicts each response and checks the ones returned.
class page_ledger;
   bit [MAX_PAGES-1:0] used_pages;
   int unsigned        fit_cursor;
   logic [LEN_W-1:0]   managed_pages;
   reply_type          expected_replies[$];
   int unsigned        errors;

   function new();
      used_pages    = '0;
      fit_cursor    = 0;
      managed_pages = LEN_W'(MAX_PAGES);
      errors        = 0;
   endfunction

   function void set_page_count(logic [LEN_W-1:0] value);
      managed_pages = value;
   endfunction

   function int unsigned pending();
      return expected_replies.size();
   endfunction

   // Managed page count, held to 1 .. MAX_PAGES.
   function int unsigned page_count();
      int unsigned n;
      n = managed_pages;
      if (n < 1) n = 1;
      if (n > MAX_PAGES) n = MAX_PAGES;
      return n;
   endfunction

   function int unsigned free_below(int unsigned n);
      int unsigned total;
      total = 0;
      for (int unsigned i = 0; i < n; i++)
         if (!used_pages[i]) total++;
      return total;
   endfunction

   // First free page at or after from and below n, or n if there is none.
   function int unsigned first_free_from(int unsigned from, int unsigned n);
      for (int unsigned i = from; i < n; i++)
         if (!used_pages[i]) return i;
      return n;
   endfunction

   // Apply one accepted request to the page map and queue its response.
   function void note_request(logic [ACTION_W-1:0] action, logic [START_W-1:0] start,
                              logic [LEN_W-1:0] len);
      int unsigned n, run, first, stop, p, hit;
      bit          may_wrap, found, searching;
      reply_type   reply;
      n     = page_count();
      run   = len;
      first = start;
      reply = '0;
      reply.status = ST_OK;
      if (action == ACT_ALLOC) begin
         if (run == 0 || run > n || run > free_below(n)) begin
            reply.status = ST_REFUSED;
         end else begin
            // Next-fit search, jumping past each used page, wrapping once.
            p         = fit_cursor;
            may_wrap  = (p != 0);
            found     = 1'b0;
            searching = 1'b1;
            while (searching) begin
               if (p <= n && run <= n - p) begin
                  hit = n;
                  for (int unsigned i = p; i < p + run && hit == n; i++)
                     if (used_pages[i]) hit = i;
                  if (hit == n) begin
                     found     = 1'b1;
                     searching = 1'b0;
                  end else begin
                     p = first_free_from(hit + 1, n);
                  end
               end else if (may_wrap) begin
                  may_wrap = 1'b0;
                  p        = 0;
               end else begin
                  searching = 1'b0;
               end
            end
            if (found) begin
               for (int unsigned i = p; i < p + run; i++) used_pages[i] = 1'b1;
               reply.granted = GRANT_W'(p);
               fit_cursor    = first_free_from(p + run, n);
            end else begin
               reply.status = ST_REFUSED;
            end
         end
      end else if (action == ACT_FREE) begin
         // Free a run clamped to the last managed page.
         if (first < n && run > 0) begin
            stop = first + run;
            if (stop > n) stop = n;
            for (int unsigned i = first; i < stop; i++) used_pages[i] = 1'b0;
         end
      end
      reply.free_count = FREE_W'(free_below(n));
      expected_replies.push_back(reply);
   endfunction

   // Compare one returned response with the oldest expected one.
   function void check_reply(logic [RSP_DATA_W-1:0] data);
      reply_type got, want;
      got.status     = data[STATUS_W-1:0];
      got.granted    = data[STATUS_W+GRANT_W-1:STATUS_W];
      got.free_count = data[STATUS_W+GRANT_W+FREE_W-1:STATUS_W+GRANT_W];
      if (expected_replies.size() == 0) begin
         $display("%0t ns: response with none expected, expected nothing, actual %h",
                  $time, data);
         errors++;
         return;
      end
      want = expected_replies.pop_front();
      if (got.status !== want.status) begin
         $display("%0t ns: status mismatch, expected %0d, actual %0d",
                  $time, want.status, got.status);
         errors++;
      end
      if (got.granted !== want.granted) begin
         $display("%0t ns: granted start mismatch, expected %0d, actual %0d",
                  $time, want.granted, got.granted);
         errors++;
      end
      if (got.free_count !== want.free_count) begin
         $display("%0t ns: free page count mismatch, expected %0d, actual %0d",
                  $time, want.free_count, got.free_count);
         errors++;
      end
   endfunction
endclass

module tb;

   localparam logic [ACTION_W-1:0] ACT_UNKNOWN = 2'd3;
   localparam int RANDOM_ITEMS = 240;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [ACTION_W-1:0]   req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [LEN_W-1:0]      csr_wdata = '0;

   // Set for the final stretch, where neither side idles.
   bit          calm = 1'b0;
   int unsigned stall_left = 0;
   page_ledger  ledger = new();

   contiguous_page_bitmap_allocator i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   // 100 MHz clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Response side: ready, broken by random stall bursts.
   always @(negedge clock) begin
      if (calm || reset) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 17);
      end
   end

   // Check every response transfer.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) ledger.check_reply(rsp_tdata);
   end

   // Drop the request valid and hold it low for the given cycles.
   task automatic hold_requests(input int unsigned cycles);
      @(negedge clock);
      req_tvalid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // Present one request, possibly after an idle burst, and wait for its transfer.
   task automatic send_request(input logic [ACTION_W-1:0] action,
                               input logic [START_W-1:0] start,
                               input logic [LEN_W-1:0] len);
      if (!calm && $urandom_range(0, 4) == 0) hold_requests($urandom_range(1, 17));
      @(negedge clock);
      req_tuser  <= action;
      req_tdata  <= {{(REQ_DATA_W - REQ_BITS){1'b0}}, len, start};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      ledger.note_request(action, start, len);
   endtask

   task automatic wait_replies_drained();
      hold_requests(1);
      while (ledger.pending() != 0) @(posedge clock);
   endtask

   // Write the managed page count while the block is idle.
   task automatic write_page_count(input logic [LEN_W-1:0] value);
      wait_replies_drained();
      @(negedge clock);
      csr_wdata <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      ledger.set_page_count(value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Edge cases on the full 256-page map from reset.
   task automatic directed_requests();
      send_request(ACT_QUERY, 8'd0, 9'd0);
      send_request(ACT_UNKNOWN, 8'd255, 9'd511);
      send_request(ACT_ALLOC, 8'd0, 9'd0);      // zero length is refused
      send_request(ACT_ALLOC, 8'd0, 9'd257);    // longer than the map
      send_request(ACT_ALLOC, 8'd255, 9'd511);
      send_request(ACT_ALLOC, 8'd0, 9'd1);
      send_request(ACT_ALLOC, 8'd0, 9'd3);
      send_request(ACT_FREE, 8'd1, 9'd1);
      send_request(ACT_ALLOC, 8'd0, 9'd2);
      send_request(ACT_ALLOC, 8'd0, 9'd250);    // fills to the end, no free page after
      send_request(ACT_ALLOC, 8'd0, 9'd1);      // wraps to the hole at page 1
      send_request(ACT_ALLOC, 8'd0, 9'd1);      // map full, refused
      send_request(ACT_FREE, 8'd255, 9'd511);   // clamped to the last page
      send_request(ACT_FREE, 8'd255, 9'd1);     // already free
      send_request(ACT_FREE, 8'd10, 9'd0);      // zero length frees nothing
      send_request(ACT_ALLOC, 8'd0, 9'd2);      // too few free pages
      send_request(ACT_ALLOC, 8'd0, 9'd1);      // wraps and skips to the last page
      send_request(ACT_FREE, 8'd0, 9'd256);
      send_request(ACT_ALLOC, 8'd0, 9'd256);    // whole map in one run
      send_request(ACT_FREE, 8'd0, 9'd511);
      send_request(ACT_FREE, 8'd100, 9'd50);
      send_request(ACT_ALLOC, 8'd0, 9'd16);
      send_request(ACT_QUERY, 8'd255, 9'd511);
   endtask

   // Mostly allocate and free traffic with random sizes, some queries and noise.
   task automatic random_requests(input int items);
      int unsigned         n, pick, size_pick, short_max;
      logic [ACTION_W-1:0] action;
      logic [START_W-1:0]  start;
      logic [LEN_W-1:0]    len;
      n         = ledger.page_count();
      short_max = (n < 16) ? n : 16;
      for (int k = 0; k < items; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45)      action = ACT_ALLOC;
         else if (pick < 85) action = ACT_FREE;
         else if (pick < 95) action = ACT_QUERY;
         else                action = ACT_UNKNOWN;
         size_pick = $urandom_range(0, 99);
         if (size_pick < 70)      len = LEN_W'($urandom_range(1, short_max));
         else if (size_pick < 88) len = LEN_W'($urandom_range(1, n));
         else if (size_pick < 94) len = '0;
         else                     len = LEN_W'($urandom_range(0, 511));
         if ($urandom_range(0, 4) != 0) start = START_W'($urandom_range(0, n - 1));
         else                           start = START_W'($urandom_range(0, 255));
         // Now and then clear the whole map to start a fresh pattern.
         if ($urandom_range(0, 49) == 0) begin
            action = ACT_FREE;
            start  = '0;
            len    = 9'd511;
         end
         // Let every response arrive before going on.
         if (k % 97 == 96) wait_replies_drained();
         send_request(action, start, len);
      end
   endtask

   // Main sequence.
   initial begin
      logic [LEN_W-1:0] phase_pages[6];
      phase_pages = '{9'd8, 9'd1, 9'd0, 9'd511, 9'd0, 9'd256};
      phase_pages[4] = LEN_W'($urandom_range(2, 255));
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      directed_requests();
      random_requests(RANDOM_ITEMS);
      foreach (phase_pages[i]) begin
         write_page_count(phase_pages[i]);
         if (i == $size(phase_pages) - 1) calm = 1'b1;
         random_requests(RANDOM_ITEMS);
      end

      wait_replies_drained();
      repeat (1000) @(posedge clock);
      if (ledger.errors == 0 && ledger.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Timeout.
   initial begin
      #100_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

### contiguous_page_bitmap_allocator.f
rtl/cpba_pkg.sv
rtl/contiguous_page_bitmap_allocator.sv
tb/sv/tb.sv
